// ===== hdl/lcfe_pkg.sv =====
// Shared types, widths and codes of the lane-center line fit block.
`timescale 1ns / 1ps
package lcfe_pkg;

  // Field widths of the channels and the configuration port.
  localparam int unsigned COL_W      = 8;
  localparam int unsigned STEER_W    = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned BIAS_W     = 8;
  localparam int unsigned MINP_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_BIAS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS  = 1'b1;

  localparam logic [BIAS_W-1:0] BIAS_RESET = 8'd0;
  localparam logic [MINP_W-1:0] MINP_RESET = 6'd8;

  localparam logic [COL_W-1:0] NO_CENTER  = 8'd255;
  localparam int unsigned      FIX_OFS    = 4;

  // Accumulator widths, sized for windows of up to 64 rows and columns up to 254.
  localparam int unsigned X_W   = 6;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned SX_W  = 11;
  localparam int unsigned SY_W  = 14;
  localparam int unsigned SXY_W = 19;
  localparam int unsigned SXX_W = 17;

  // Fit datapath widths.
  localparam int unsigned A_W    = 28;
  localparam int unsigned B_W    = 24;
  localparam int unsigned P_W    = A_W + B_W;
  localparam int unsigned NUM_W  = 40;
  localparam int unsigned DEN_W  = 24;
  localparam int unsigned NA_W   = 27;
  localparam int unsigned T_W    = 13;
  localparam int unsigned DD_W   = 29;
  localparam int unsigned PRED_W = 8;
  localparam int unsigned DIVC_W = $clog2(NUM_W + 1);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_F1,
    OP_F2,
    OP_F3,
    OP_F4,
    OP_F5,
    OP_F6,
    OP_F7,
    OP_F8,
    OP_F9,
    OP_F10,
    OP_DIV,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e  op;
    logic in_fire;
  } cmd_t;

  typedef struct packed {
    logic last_row;
    logic div_last;
  } sts_t;

endpackage

// ===== hdl/lcfe_dp.sv =====
// Datapath: window accumulators, shared multiplier, serial divider and output register.
`timescale 1ns / 1ps
module lcfe_dp #(
  parameter int unsigned ROWS_PER_FIT = 40,
  parameter int unsigned IMAGE_WIDTH  = 188
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lcfe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lcfe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [lcfe_pkg::COL_W-1:0]         center_col_i,
  input  logic                               last_row_i,
  input  lcfe_pkg::cmd_t                     cmd_i,
  output lcfe_pkg::sts_t                     sts_o,
  output logic signed [lcfe_pkg::STEER_W-1:0] steer_error_o,
  output logic                               used_fallback_o
);
  import lcfe_pkg::*;

  localparam int unsigned RIDX_W = $clog2(ROWS_PER_FIT + 1);
  localparam int unsigned HALF_W = IMAGE_WIDTH / 2;

  // Configuration and window state.
  logic signed [BIAS_W-1:0]  bias_q;
  logic [MINP_W-1:0]         minp_q;
  logic [RIDX_W-1:0]         row_idx_q, row_idx_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [SX_W-1:0]           sx_q, sx_d;
  logic [SY_W-1:0]           sy_q, sy_d;
  logic [SXY_W-1:0]          sxy_q, sxy_d;
  logic [SXX_W-1:0]          sxx_q, sxx_d;
  logic signed [STEER_W-1:0] last_err_q;
  logic [DIVC_W-1:0]         div_cnt_q;

  // Payload registers.
  logic [COL_W-1:0]          col_q;
  logic                      last_q;
  logic signed [NUM_W-1:0]   prod_q;
  logic signed [DEN_W-1:0]   den_q;
  logic signed [NA_W-1:0]    na_q;
  logic signed [T_W-1:0]     t_q;
  logic signed [NUM_W-1:0]   num_q;
  logic [DD_W-1:0]           dd_q;
  logic [DD_W-1:0]           rem_q;
  logic                      neg_q;
  logic signed [STEER_W-1:0] steer_q;
  logic                      fb_q;

  // Row accumulation terms.
  logic [X_W-1:0]            x;
  logic [X_W+COL_W-1:0]      xy;
  logic [2*X_W-1:0]          xx;
  logic                      in_range;

  assign x        = X_W'(row_idx_q);
  assign xy       = (X_W+COL_W)'(x) * (X_W+COL_W)'(col_q);
  assign xx       = (2*X_W)'(x) * (2*X_W)'(x);
  assign in_range = row_idx_q < RIDX_W'(ROWS_PER_FIT);

  always_comb begin
    row_idx_d = row_idx_q;
    cnt_d     = cnt_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    sxy_d     = sxy_q;
    sxx_d     = sxx_q;
    if (cmd_i.op == OP_ACC && in_range) begin
      row_idx_d = row_idx_q + RIDX_W'(1);
      if (col_q != NO_CENTER) begin
        cnt_d = cnt_q + CNT_W'(1);
        sx_d  = sx_q + SX_W'(x);
        sy_d  = sy_q + SY_W'(col_q);
        sxy_d = sxy_q + SXY_W'(xy);
        sxx_d = sxx_q + SXX_W'(xx);
      end
    end else if (cmd_i.op == OP_FIN) begin
      row_idx_d = '0;
      cnt_d     = '0;
      sx_d      = '0;
      sy_d      = '0;
      sxy_d     = '0;
      sxx_d     = '0;
    end
  end

  // Shared multiplier operand select.
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [P_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_F1: begin
        mul_a = A_W'(cnt_q);
        mul_b = B_W'(sxx_q);
      end
      OP_F2: begin
        mul_a = A_W'(sx_q);
        mul_b = B_W'(sx_q);
      end
      OP_F3: begin
        mul_a = A_W'(cnt_q);
        mul_b = B_W'(sxy_q);
      end
      OP_F4: begin
        mul_a = A_W'(sx_q);
        mul_b = B_W'(sy_q);
      end
      OP_F5: begin
        mul_a = A_W'(cnt_q);
        mul_b = B_W'(ROWS_PER_FIT - 1);
      end
      OP_F7: begin
        mul_a = A_W'(na_q);
        mul_b = B_W'(t_q);
      end
      OP_F8: begin
        mul_a = A_W'(sy_q);
        mul_b = B_W'(den_q);
      end
      OP_F9: begin
        mul_a = A_W'(cnt_q);
        mul_b = B_W'(den_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Restoring divider step.
  logic [DD_W:0] div_shift;
  logic          div_ge;

  assign div_shift = {rem_q, num_q[NUM_W-1]};
  assign div_ge    = div_shift >= {1'b0, dd_q};

  // Result forming.
  logic [PRED_W-1:0]         pred;
  logic                      fallback;
  logic signed [STEER_W-1:0] err_new;
  logic signed [STEER_W-1:0] steer_fit;
  logic signed [STEER_W-1:0] steer_fb;

  always_comb begin
    if (neg_q) begin
      pred = '0;
    end else if ($unsigned(num_q) >= NUM_W'(IMAGE_WIDTH)) begin
      pred = PRED_W'(IMAGE_WIDTH - 1);
    end else begin
      pred = num_q[PRED_W-1:0];
    end
  end

  assign fallback  = (CNT_W'(minp_q) > cnt_q) || den_q[DEN_W-1] || (den_q == '0);
  assign err_new   = STEER_W'(HALF_W) - STEER_W'(pred);
  assign steer_fit = STEER_W'(FIX_OFS) - err_new + STEER_W'(bias_q);
  assign steer_fb  = last_err_q + STEER_W'(bias_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q     <= BIAS_RESET;
      minp_q     <= MINP_RESET;
      row_idx_q  <= '0;
      cnt_q      <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      sxy_q      <= '0;
      sxx_q      <= '0;
      last_err_q <= '0;
      div_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CORNER_BIAS: bias_q <= cfg_data_i[BIAS_W-1:0];
          CFG_MIN_POINTS:  minp_q <= cfg_data_i[MINP_W-1:0];
          default:         bias_q <= bias_q;
        endcase
      end
      row_idx_q <= row_idx_d;
      cnt_q     <= cnt_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      sxy_q     <= sxy_d;
      sxx_q     <= sxx_d;
      if (cmd_i.op == OP_F10) begin
        div_cnt_q <= DIVC_W'(NUM_W);
      end else if (cmd_i.op == OP_DIV) begin
        div_cnt_q <= div_cnt_q - DIVC_W'(1);
      end
      if (cmd_i.op == OP_FIN && !fallback) begin
        last_err_q <= err_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_fire) begin
      col_q  <= center_col_i;
      last_q <= last_row_i;
    end
    prod_q <= NUM_W'(mul_p);
    unique case (cmd_i.op)
      OP_F2:  den_q <= DEN_W'(prod_q);
      OP_F3:  den_q <= den_q - DEN_W'(prod_q);
      OP_F4:  na_q  <= NA_W'(prod_q);
      OP_F5:  na_q  <= na_q - NA_W'(prod_q);
      OP_F6:  t_q   <= T_W'(prod_q) - T_W'(sx_q);
      OP_F8:  num_q <= prod_q;
      OP_F9:  num_q <= num_q + prod_q;
      OP_F10: begin
        dd_q  <= DD_W'(prod_q);
        rem_q <= '0;
        neg_q <= num_q[NUM_W-1];
      end
      OP_DIV: begin
        rem_q <= div_ge ? DD_W'(div_shift - {1'b0, dd_q}) : DD_W'(div_shift);
        num_q <= {num_q[NUM_W-2:0], div_ge};
      end
      OP_FIN: begin
        steer_q <= fallback ? steer_fb : steer_fit;
        fb_q    <= fallback;
      end
      default: begin
        dd_q <= dd_q;
      end
    endcase
  end

  assign sts_o.last_row = last_q;
  assign sts_o.div_last = div_cnt_q == DIVC_W'(1);

  assign steer_error_o   = steer_q;
  assign used_fallback_o = fb_q;

endmodule

// ===== hdl/lcfe_ctrl.sv =====
// Controller: sequences row accumulation, fit steps, division and result hand-off.
`timescale 1ns / 1ps
module lcfe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  lcfe_pkg::sts_t sts_i,
  output lcfe_pkg::cmd_t cmd_o
);
  import lcfe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_F5,
    ST_F6,
    ST_F7,
    ST_F8,
    ST_F9,
    ST_F10,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   in_fire;

  assign in_ready_o  = state_q == ST_IDLE;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.in_fire = in_fire;
    unique case (state_q)
      ST_IDLE: cmd_o.op = OP_NONE;
      ST_ACC:  cmd_o.op = OP_ACC;
      ST_F1:   cmd_o.op = OP_F1;
      ST_F2:   cmd_o.op = OP_F2;
      ST_F3:   cmd_o.op = OP_F3;
      ST_F4:   cmd_o.op = OP_F4;
      ST_F5:   cmd_o.op = OP_F5;
      ST_F6:   cmd_o.op = OP_F6;
      ST_F7:   cmd_o.op = OP_F7;
      ST_F8:   cmd_o.op = OP_F8;
      ST_F9:   cmd_o.op = OP_F9;
      ST_F10:  cmd_o.op = OP_F10;
      ST_DIV:  cmd_o.op = OP_DIV;
      ST_FIN:  cmd_o.op = out_free ? OP_FIN : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (in_fire) state_q <= ST_ACC;
        ST_ACC:  state_q <= sts_i.last_row ? ST_F1 : ST_IDLE;
        ST_F1:   state_q <= ST_F2;
        ST_F2:   state_q <= ST_F3;
        ST_F3:   state_q <= ST_F4;
        ST_F4:   state_q <= ST_F5;
        ST_F5:   state_q <= ST_F6;
        ST_F6:   state_q <= ST_F7;
        ST_F7:   state_q <= ST_F8;
        ST_F8:   state_q <= ST_F9;
        ST_F9:   state_q <= ST_F10;
        ST_F10:  state_q <= ST_DIV;
        ST_DIV:  if (sts_i.div_last) state_q <= ST_FIN;
        ST_FIN:  if (out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Every accepted row is accumulated in the very next cycle.
  a_fire_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (cmd_o.op == OP_ACC))
    else $error("accepted row not accumulated next cycle");

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_FIN) |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // A loaded result is presented in the following cycle.
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_FIN) |=> out_valid_q)
    else $error("loaded result not presented");

  // The divider runs until its last step before the result is formed.
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !sts_i.div_last) |=> (state_q == ST_DIV))
    else $error("division left early");

endmodule

// ===== hdl/lane_center_line_fit_error.sv =====
// Top level of the lane-center least-squares line fit and steering error block.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one lane-center column per
//   image row; center_col_i = 255 marks a row without a center, last_row_i
//   closes the fit window. Each transaction on the output channel
//   (out_valid_o / out_ready_i) carries one steering error, produced only for
//   rows with last_row_i set.
//   Sequence: an ordinary row is accepted, then accumulated through a small
//   row*column multiplier before the next row is accepted. A last row is
//   accepted and accumulated, then passes the fit steps, which form the fit
//   terms on the single shared 28x24 multiplier, the one-bit-per-cycle
//   restoring divider and a final step that registers the result.
//   The output register parts the two sides: further rows are accepted while a
//   result waits. Only when a new fit finishes and the previous result is still
//   unclaimed does the block hold in its final step, so a stalled receiver
//   backs up the input only at the next window end.
//   Reset (rst_ni low, asynchronous) empties the window, clears the stored
//   error, sets corner_bias to 0 and min_points to 8, and drops out_valid_o.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
//   clock edge, with index 0 for corner_bias and 1 for min_points.
module lane_center_line_fit_error #(
  parameter int unsigned ROWS_PER_FIT = 40,
  parameter int unsigned IMAGE_WIDTH  = 188
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcfe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lcfe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lcfe_pkg::COL_W-1:0]          center_col_i,
  input  logic                                last_row_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lcfe_pkg::STEER_W-1:0] steer_error_o,
  output logic                                used_fallback_o
);
  import lcfe_pkg::*;

  // Command and status between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns the handshakes and steps the fit.
  lcfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: sums, fit arithmetic, divider, stored error and result register.
  lcfe_dp #(
    .ROWS_PER_FIT (ROWS_PER_FIT),
    .IMAGE_WIDTH  (IMAGE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .center_col_i    (center_col_i),
    .last_row_i      (last_row_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .steer_error_o   (steer_error_o),
    .used_fallback_o (used_fallback_o)
  );

endmodule
